[sv/lsbfr_pkg.sv]
// ----------------------------------------------------------------------------
// lsbfr_pkg
// Shared types, operation codes and helpers of the LSB-first field reader.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbfr_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_RANGED = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    localparam int FIELD_BITS           = 32;
    localparam int DEFAULT_BUFFER_BYTES = 256;
    // Command queue depth, a power of two
    localparam int QUEUE_DEPTH          = 2;

    // Classified command passed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_value;
        logic [5:0]  width;      // bits to extract, 0 to 32
        logic [31:0] base;       // added to the extracted bits
    } t_cmd;

    // Bit length of a 32-bit word (priority encode of the top set bit)
    function automatic logic [5:0] bit_length32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (x[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[sv/lsbfr_front.sv]
// ----------------------------------------------------------------------------
// lsbfr_front
// Classifies an incoming request: works out the field width and the base
// value that the back end adds after extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbfr_front (
    input  wire logic [1:0]       i_operation,
    input  wire logic [7:0]       i_byte_value,
    input  wire logic [7:0]       i_bit_count,
    input  wire logic [31:0]      i_range_min,
    input  wire logic [31:0]      i_range_max,
    output lsbfr_pkg::t_cmd       o_cmd
);

    logic [31:0] span;

    assign span = i_range_max - i_range_min;

    // Derive width and base per operation
    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = i_operation;
        o_cmd.byte_value = i_byte_value;
        unique case (i_operation)
            lsbfr_pkg::OP_READ: begin
                if (i_bit_count >= 8'd1 && i_bit_count <= 8'(lsbfr_pkg::FIELD_BITS)) begin
                    o_cmd.width = i_bit_count[5:0];
                end
            end
            lsbfr_pkg::OP_RANGED: begin
                o_cmd.width = lsbfr_pkg::bit_length32(span);
                o_cmd.base  = i_range_min;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/lsbfr_queue.sv]
// ----------------------------------------------------------------------------
// lsbfr_queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbfr_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lsbfr_pkg::t_cmd  i_cmd,
    input  wire logic             i_pop,
    output lsbfr_pkg::t_cmd       o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int DEPTH = lsbfr_pkg::QUEUE_DEPTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lsbfr_pkg::t_cmd r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTRW:0]   r_level, n_level;
    logic            do_push, do_pop;

    assign o_full  = (r_level == (PTRW + 1)'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and level
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_level  = r_level;
        if (do_push && !do_pop) begin
            n_level = r_level + 1'b1;
        end else if (do_pop && !do_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/lsbfr_back.sv]
// ----------------------------------------------------------------------------
// lsbfr_back
// Executes commands: appends bytes to the store, restarts the buffer, and
// extracts fields byte by byte from the running bit position.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbfr_back #(
    parameter int BUFFER_BYTES = lsbfr_pkg::DEFAULT_BUFFER_BYTES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lsbfr_pkg::t_cmd  i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_result_valid,
    output logic [31:0]           o_field_value,
    output logic                  o_short_read
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = CW + 3;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_ADDR = 2'd1;
    localparam logic [1:0] B_DATA = 2'd2;

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_pos, n_pos;
    logic [5:0]    r_width, n_width;
    logic [5:0]    r_got, n_got;
    logic [31:0]   r_value, n_value;
    logic [31:0]   r_base, n_base;
    logic          r_valid, n_valid;
    logic [31:0]   r_out, n_out;
    logic          r_short, n_short;

    logic          wr_en, rd_en;
    logic [CW-1:0] idx;
    logic [2:0]    off;
    logic [3:0]    avail;
    logic [5:0]    rem;
    logic [3:0]    take;
    logic [7:0]    mask;
    logic [7:0]    chunk;

    assign idx   = r_pos[PW-1:3];
    assign off   = r_pos[2:0];
    assign avail = 4'd8 - {1'b0, off};
    assign rem   = r_width - r_got;
    assign take  = (rem < {2'b00, avail}) ? rem[3:0] : avail;
    assign mask  = 8'((9'd1 << take) - 9'd1);
    assign chunk = (r_rdata >> off) & mask;

    assign o_pop          = (r_state == B_IDLE) && !i_empty;
    assign wr_en          = o_pop && (i_head.op == lsbfr_pkg::OP_APPEND)
                            && (r_count < CW'(BUFFER_BYTES));
    assign rd_en          = (r_state == B_ADDR) && (r_got != r_width) && (idx < r_count);
    assign o_result_valid = r_valid;
    assign o_field_value  = r_out;
    assign o_short_read   = r_short;

    // Sequence commands and gather field bits
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_width = r_width;
        n_got   = r_got;
        n_value = r_value;
        n_base  = r_base;
        n_valid = 1'b0;
        n_out   = r_out;
        n_short = r_short;
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    case (i_head.op)
                        lsbfr_pkg::OP_APPEND: begin
                            if (wr_en) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        lsbfr_pkg::OP_START: begin
                            n_count = '0;
                            n_pos   = '0;
                        end
                        default: begin
                            n_width = i_head.width;
                            n_base  = i_head.base;
                            n_got   = '0;
                            n_value = '0;
                            n_state = B_ADDR;
                        end
                    endcase
                end
            end
            B_ADDR: begin
                if (r_got == r_width) begin
                    n_valid = 1'b1;
                    n_out   = r_value + r_base;
                    n_short = 1'b0;
                    n_state = B_IDLE;
                end else if (!(idx < r_count)) begin
                    n_valid = 1'b1;
                    n_out   = r_value + r_base;
                    n_short = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    n_state = B_DATA;
                end
            end
            B_DATA: begin
                n_value = r_value | ({24'd0, chunk} << r_got[4:0]);
                n_got   = r_got + {2'b00, take};
                n_pos   = r_pos + PW'(take);
                n_state = B_ADDR;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_got   <= n_got;
        r_value <= n_value;
        r_base  <= n_base;
        r_out   <= n_out;
        r_short <= n_short;
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_head.byte_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[idx[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

[sv/lsb_first_bit_field_reader.sv]
// ----------------------------------------------------------------------------
// lsb_first_bit_field_reader
// Loads a packet byte by byte and extracts fields LSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on the i_* fields with start high; it is taken at the
//   clock edge where busy is low. Append (0) and start-new-buffer (3) give
//   no result. Plain read (1) and ranged read (2) give one result, shown on
//   o_field_value and o_short_read for a single cycle with o_result_valid.
//   The receiver cannot stall; each result must be captured when strobed.
// Timing:
//   A request enters a two-entry command queue; busy is high while it is
//   full. The back end takes a command only in its idle state; append and
//   start then finish. A read alternates between an address state
//   (registered store read) and a data state (merge) for each touched
//   byte, then returns to idle as it strobes the result; the single read
//   port of the byte store means each touched byte needs its own read.
// Reset:
//   Synchronous reset empties the queue and sets byte count and bit
//   position to zero. The byte store is not cleared; bytes beyond the
//   loaded count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_first_bit_field_reader #(
    parameter int BUFFER_BYTES = lsbfr_pkg::DEFAULT_BUFFER_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [7:0]  i_bit_count,
    input  wire logic [31:0] i_range_min,
    input  wire logic [31:0] i_range_max,
    output logic             o_result_valid,
    output logic [31:0]      o_field_value,
    output logic             o_short_read
);

    lsbfr_pkg::t_cmd cmd_in;
    lsbfr_pkg::t_cmd cmd_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    assign busy = q_full;

    // Classify requests
    lsbfr_front u_front (
        .i_operation  (i_operation),
        .i_byte_value (i_byte_value),
        .i_bit_count  (i_bit_count),
        .i_range_min  (i_range_min),
        .i_range_max  (i_range_max),
        .o_cmd        (cmd_in)
    );

    // Queue classified commands
    lsbfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_cmd   (cmd_in),
        .i_pop   (q_pop),
        .o_head  (cmd_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Execute commands
    lsbfr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (cmd_head),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .o_field_value  (o_field_value),
        .o_short_read   (o_short_read)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LSB-first bit field reader: directed packets
// cover the corner cases, random packets cover the rest, and every result is
// checked against a local model of the byte store and bit position.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int STORE_BYTES    = lsbfr_pkg::DEFAULT_BUFFER_BYTES;
    localparam int ITEM_GOAL      = 1550;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 50;

    typedef struct {
        logic [31:0] value;
        logic        short_flag;
    } t_field_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_byte_value;
    logic [7:0]  i_bit_count;
    logic [31:0] i_range_min;
    logic [31:0] i_range_max;
    logic        o_result_valid;
    logic [31:0] o_field_value;
    logic        o_short_read;

    // Local copy of the reader state
    logic [7:0]    packet_bytes [0:STORE_BYTES-1];
    int            loaded_bytes;
    int            read_pos;
    t_field_result pending_fields [$];
    t_field_result head_result;

    int  error_count;
    int  requests_sent;
    int  reads_sent;
    int  short_reads;
    int  appends_sent;
    int  appends_dropped;
    int  buffer_starts;
    bit  idle_enabled;

    lsb_first_bit_field_reader #(
        .BUFFER_BYTES (STORE_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_byte_value   (i_byte_value),
        .i_bit_count    (i_bit_count),
        .i_range_min    (i_range_min),
        .i_range_max    (i_range_max),
        .o_result_valid (o_result_valid),
        .o_field_value  (o_field_value),
        .o_short_read   (o_short_read)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch @%0t: %s, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Pull width bits LSB first from the running position
    function automatic logic [31:0] pull_bits(input int width, output logic ran_out);
        logic [31:0] acc;
        logic [31:0] chunk;
        int          got;
        int          idx;
        int          off;
        int          take;
        acc     = '0;
        got     = 0;
        ran_out = 1'b0;
        while (got < width) begin
            idx = read_pos >> 3;
            off = read_pos & 7;
            if (idx >= loaded_bytes) begin
                ran_out = 1'b1;
                break;
            end
            take = 8 - off;
            if (take > width - got) begin
                take = width - got;
            end
            chunk    = 32'(packet_bytes[idx] >> off) & ((32'd1 << take) - 32'd1);
            acc      = acc | (chunk << got);
            got      = got + take;
            read_pos = read_pos + take;
        end
        return acc;
    endfunction

    // Advance the local state for one accepted request, queue any result
    task automatic predict_request(input logic [1:0] op, input logic [7:0] bval,
                                   input logic [7:0] nbits, input logic [31:0] lo,
                                   input logic [31:0] hi);
        t_field_result res;
        logic [31:0]   span;
        int            width;
        res.value      = '0;
        res.short_flag = 1'b0;
        case (op)
            lsbfr_pkg::OP_APPEND: begin
                appends_sent++;
                if (loaded_bytes < STORE_BYTES) begin
                    packet_bytes[loaded_bytes] = bval;
                    loaded_bytes++;
                end else begin
                    appends_dropped++;
                end
            end
            lsbfr_pkg::OP_START: begin
                buffer_starts++;
                loaded_bytes = 0;
                read_pos     = 0;
            end
            default: begin
                if (op == lsbfr_pkg::OP_READ) begin
                    if (nbits >= 8'd1 && nbits <= 8'd32) begin
                        res.value = pull_bits(int'(nbits), res.short_flag);
                    end
                end else begin
                    span  = hi - lo;
                    width = 0;
                    while (span != 0) begin
                        width++;
                        span = span >> 1;
                    end
                    res.value = pull_bits(width, res.short_flag) + lo;
                end
                reads_sent++;
                if (res.short_flag) begin
                    short_reads++;
                end
                pending_fields.push_back(res);
            end
        endcase
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] op, input logic [7:0] bval,
                                input logic [7:0] nbits, input logic [31:0] lo,
                                input logic [31:0] hi);
        int gap;
        if (idle_enabled && $urandom_range(99) < 25) begin
            @(negedge i_clk);
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_operation  <= op;
        i_byte_value <= bval;
        i_bit_count  <= nbits;
        i_range_min  <= lo;
        i_range_max  <= hi;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_request(op, bval, nbits, lo, hi);
        requests_sent++;
    endtask

    task automatic send_read(input logic [7:0] nbits);
        send_request(lsbfr_pkg::OP_READ, 8'h00, nbits, 32'h0, 32'h0);
    endtask

    task automatic send_ranged(input logic [31:0] lo, input logic [31:0] hi);
        send_request(lsbfr_pkg::OP_RANGED, 8'h00, 8'h00, lo, hi);
    endtask

    task automatic send_append(input logic [7:0] bval);
        send_request(lsbfr_pkg::OP_APPEND, bval, 8'h00, 32'h0, 32'h0);
    endtask

    // Plain or ranged read with random widths and random idle fields
    task automatic send_random_read();
        logic [7:0]  nbits;
        logic [31:0] lo;
        logic [31:0] span;
        int          width;
        if ($urandom_range(1) == 0) begin
            nbits = ($urandom_range(99) < 85) ? 8'($urandom_range(32, 1)) : 8'($urandom);
            send_request(lsbfr_pkg::OP_READ, 8'($urandom), nbits, $urandom, $urandom);
        end else begin
            lo    = $urandom;
            width = $urandom_range(32, 0);
            span  = (width == 0) ? 32'h0 : ($urandom >> (32 - width));
            if ($urandom_range(99) < 10) begin
                send_request(lsbfr_pkg::OP_RANGED, 8'($urandom), 8'($urandom), lo,
                             $urandom);
            end else begin
                send_request(lsbfr_pkg::OP_RANGED, 8'($urandom), 8'($urandom), lo,
                             lo + span);
            end
        end
    endtask

    // Empty buffer, width extremes, byte crossings, wraps, short reads
    task automatic test_directed_packet();
        send_read(8'd8);
        send_ranged(32'd5, 32'd5);
        send_append(8'hFF);
        send_append(8'h00);
        send_append(8'hA5);
        send_append(8'h5A);
        send_append(8'h3C);
        send_append(8'hC3);
        send_read(8'd0);
        send_read(8'd33);
        send_read(8'd255);
        send_read(8'd1);
        send_read(8'd3);
        send_read(8'd32);
        send_read(8'd7);
        send_ranged(32'hFFFF_FFF0, 32'h0000_000F);
        send_read(8'd4);
        send_append(8'h81);
        send_read(8'd8);
        send_append(8'h01);
        send_append(8'h80);
        send_append(8'h7E);
        send_append(8'hE7);
        send_ranged(32'h8000_0000, 32'h7FFF_FFFF);
        send_append(8'hF0);
        send_ranged(32'h0000_0001, 32'h0001_0000);
        send_request(lsbfr_pkg::OP_START, 8'h00, 8'h00, 32'h0, 32'h0);
        send_read(8'd8);
    endtask

    // Fill past capacity, then read the whole store and run off its end
    task automatic test_full_store();
        send_request(lsbfr_pkg::OP_START, 8'($urandom), 8'($urandom), $urandom, $urandom);
        repeat (STORE_BYTES + 4) send_append(8'($urandom));
        while (read_pos < 8 * loaded_bytes) begin
            if ($urandom_range(3) == 0) begin
                send_random_read();
            end else begin
                send_read(8'd32);
            end
        end
        send_read(8'd32);
        send_ranged(32'h0, 32'hFFFF_FFFF);
    endtask

    // Mostly well-formed packets with random content, plus some noise
    task automatic test_random_packets(input int item_goal);
        int n_bytes;
        while (requests_sent < item_goal) begin
            idle_enabled = !(requests_sent >= 700 && requests_sent < 1000);
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(6, 1)) begin
                    send_request(2'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
                end
            end else begin
                send_request(lsbfr_pkg::OP_START, 8'($urandom), 8'($urandom),
                             $urandom, $urandom);
                // Keep long packets away from the end of the run
                n_bytes = ($urandom_range(99) < 4 && requests_sent + 400 < item_goal)
                          ? $urandom_range(270, 200) : $urandom_range(12, 1);
                repeat (n_bytes) begin
                    send_request(lsbfr_pkg::OP_APPEND, 8'($urandom), 8'($urandom),
                                 $urandom, $urandom);
                end
                while (read_pos < 8 * loaded_bytes) begin
                    if ($urandom_range(99) < 10) begin
                        send_request(lsbfr_pkg::OP_APPEND, 8'($urandom), 8'($urandom),
                                     $urandom, $urandom);
                    end
                    send_random_read();
                end
                if ($urandom_range(1) == 1) begin
                    send_random_read();
                end
            end
        end
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_fields.size() == 0) begin
                report_mismatch("result with nothing pending", 32'h0, o_field_value);
            end else begin
                head_result = pending_fields.pop_front();
                if (o_field_value !== head_result.value) begin
                    report_mismatch("field_value", head_result.value, o_field_value);
                end
                if (o_short_read !== head_result.short_flag) begin
                    report_mismatch("short_read", 32'(head_result.short_flag),
                                    32'(o_short_read));
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results pending",
                 TIMEOUT_CYCLES, pending_fields.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_operation     = lsbfr_pkg::OP_APPEND;
        i_byte_value    = '0;
        i_bit_count     = '0;
        i_range_min     = '0;
        i_range_max     = '0;
        loaded_bytes    = 0;
        read_pos        = 0;
        error_count     = 0;
        requests_sent   = 0;
        reads_sent      = 0;
        short_reads     = 0;
        appends_sent    = 0;
        appends_dropped = 0;
        buffer_starts   = 0;
        idle_enabled    = 1'b1;
        for (int i = 0; i < STORE_BYTES; i++) begin
            packet_bytes[i] = '0;
        end

        // Hold reset, then release away from the active edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_packet();
        test_full_store();
        test_random_packets(ITEM_GOAL);

        // Drop the request line and drain
        @(negedge i_clk);
        start <= 1'b0;
        for (int i = 0; i < DRAIN_CYCLES && pending_fields.size() != 0; i++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_fields.size() != 0) begin
            report_mismatch("results never delivered", 32'h0, 32'(pending_fields.size()));
        end

        $display("coverage: %0d requests, %0d reads (%0d short), %0d appends (%0d dropped)",
                 requests_sent, reads_sent, short_reads, appends_sent, appends_dropped);
        $display("coverage: %0d buffer starts, %0d mismatches", buffer_starts, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

[lsb_first_bit_field_reader.f]
sv/lsbfr_pkg.sv
sv/lsbfr_front.sv
sv/lsbfr_queue.sv
sv/lsbfr_back.sv
sv/lsb_first_bit_field_reader.sv
test/tb.sv
